// ===== hw/rtl/rkm_pkg.sv =====
// ----------------------------------------------------------------------------
// rkm_pkg
// Types, constants and codes shared by the remapped keypoint matcher.
// ----------------------------------------------------------------------------
package rkm_pkg;

  localparam int MAX_POINTS  = 128;
  localparam int MAX_DIM     = 4096;
  localparam int PIDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W       = PIDX_W + 1;
  localparam int DIM_W       = $clog2(MAX_DIM) + 1;
  localparam int COORD_W     = 12;
  localparam int KEY_W       = 16;
  localparam int FRAC_W      = 4;
  localparam int SQ_W        = 2 * KEY_W;
  localparam int DIST_W      = SQ_W + 1;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // one pixel squared in 1/256 units
  localparam logic [DIST_W-1:0] ONE_PIXEL_SQ = DIST_W'(256);

  // configuration register indexes
  localparam logic [1:0] CFG_POINT_COUNT = 2'd0;
  localparam logic [1:0] CFG_IMAGE_WIDTH = 2'd1;
  localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd2;
  localparam logic [1:0] CFG_THRESHOLD   = 2'd3;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_PIXEL = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_SCAN,
    CMD_READ,
    CMD_ZERO
  } cmd_kind_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SCAN,
    B_DRAIN,
    B_COMMIT,
    B_READ
  } back_state_t;

  typedef struct packed {
    logic [1:0]         operation;
    logic [PIDX_W-1:0]  point_index;
    logic [KEY_W-1:0]   point_x;
    logic [KEY_W-1:0]   point_y;
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [7:0]         intensity;
    logic signed [15:0] map_x;
    logic signed [15:0] map_y;
  } in_item_t;

  typedef struct packed {
    logic [PIDX_W-1:0]  matched_index;
    logic               accepted;
    logic               has_match;
    logic [COORD_W-1:0] match_x;
    logic [COORD_W-1:0] match_y;
  } out_item_t;

  typedef struct packed {
    logic [CNT_W-1:0] point_count;
    logic [DIM_W-1:0] image_width;
    logic [DIM_W-1:0] image_height;
    logic [7:0]       intensity_threshold;
  } cfg_regs_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [PIDX_W-1:0]  idx;
    logic [KEY_W-1:0]   key_x;
    logic [KEY_W-1:0]   key_y;
    logic [COORD_W-1:0] src_x;
    logic [COORD_W-1:0] src_y;
    logic [COORD_W-1:0] pix_x;
    logic [COORD_W-1:0] pix_y;
    logic [CNT_W-1:0]   count;
  } cmd_t;

endpackage

// ===== hw/rtl/remapped_keypoint_matcher_core.sv =====
// ----------------------------------------------------------------------------
// remapped_keypoint_matcher_core
// Keypoint table with nearest-keypoint matching of remapped pixels.
//
//   channel  direction  handshake           payload
//   in_      in         in_valid/in_stall   rkm_pkg::in_item_t
//   out_     out        out_valid/out_stall rkm_pkg::out_item_t
//   cfg_     in         cfg_valid/cfg_ready cfg_index, cfg_data
//
// Loads and skipped pixels finish in the idle state; reads pass through B_READ.
// Searched pixel: one key read for each of point_count (at most 128) keys.
// A 2-entry command queue keeps taking items while the back end is busy.
// Synchronous active-low reset clears control, match flags; sets cfg defaults.
// out_stall holds the result register and, via the queue, backs up in_stall.
// ----------------------------------------------------------------------------
module remapped_keypoint_matcher_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rkm_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output rkm_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [12:0]        cfg_data
);
  import rkm_pkg::*;

  cfg_regs_t cfg_r;
  cmd_t      front_cmd;
  cmd_t      head_cmd;
  logic      q_full, q_head_valid, q_pop, push;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign push      = in_valid && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.point_count         <= CNT_W'(99);
      cfg_r.image_width         <= DIM_W'(640);
      cfg_r.image_height        <= DIM_W'(480);
      cfg_r.intensity_threshold <= 8'd10;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_POINT_COUNT:  cfg_r.point_count         <= cfg_data[CNT_W-1:0];
        CFG_IMAGE_WIDTH:  cfg_r.image_width         <= cfg_data[DIM_W-1:0];
        CFG_IMAGE_HEIGHT: cfg_r.image_height        <= cfg_data[DIM_W-1:0];
        CFG_THRESHOLD:    cfg_r.intensity_threshold <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  rkm_front u_front (
    .in_item (in_item),
    .cfg     (cfg_r),
    .cmd     (front_cmd)
  );

  rkm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (front_cmd),
    .full       (q_full),
    .head_valid (q_head_valid),
    .head_cmd   (head_cmd),
    .pop        (q_pop)
  );

  rkm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_head_valid),
    .q_cmd     (head_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

`ifndef SYNTHESIS
  a_reset_no_result: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  a_accept_or_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_item.accepted && out_item.has_match))
    else $error("pixel result and read result mixed");

  a_no_match_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.accepted && !out_item.has_match) |->
      (out_item.match_x == '0 && out_item.match_y == '0))
    else $error("match position set without a match");

  a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_head_valid)
    else $error("queue popped while empty");
`endif

endmodule

// ===== hw/rtl/rkm_front.sv =====
// ----------------------------------------------------------------------------
// rkm_front
// Decodes input items and screens pixels against the image bounds and the
// intensity threshold and a zero point count, making back-end commands.
// ----------------------------------------------------------------------------
module rkm_front (
  input  rkm_pkg::in_item_t  in_item,
  input  rkm_pkg::cfg_regs_t cfg,
  output rkm_pkg::cmd_t      cmd
);
  import rkm_pkg::*;

  logic [DIM_W-1:0] w_sat;
  logic [DIM_W-1:0] h_sat;
  logic [CNT_W-1:0] n_sat;
  logic             x_ok;
  logic             y_ok;
  logic             take;

  always_comb begin
    w_sat = (cfg.image_width > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : cfg.image_width;
    h_sat = (cfg.image_height > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : cfg.image_height;
    n_sat = (cfg.point_count > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : cfg.point_count;

    x_ok = !in_item.map_x[15] && ({1'b0, in_item.map_x[14:0]} < 16'(w_sat));
    y_ok = !in_item.map_y[15] && ({1'b0, in_item.map_y[14:0]} < 16'(h_sat));
    take = (in_item.intensity > cfg.intensity_threshold) && (n_sat != '0) && x_ok && y_ok;

    cmd.idx   = in_item.point_index;
    cmd.key_x = in_item.point_x;
    cmd.key_y = in_item.point_y;
    cmd.src_x = in_item.map_x[COORD_W-1:0];
    cmd.src_y = in_item.map_y[COORD_W-1:0];
    cmd.pix_x = in_item.pixel_x;
    cmd.pix_y = in_item.pixel_y;
    cmd.count = n_sat;

    unique case (in_item.operation)
      OP_LOAD:  cmd.kind = CMD_LOAD;
      OP_PIXEL: cmd.kind = take ? CMD_SCAN : CMD_ZERO;
      OP_READ:  cmd.kind = CMD_READ;
      default:  cmd.kind = CMD_ZERO;
    endcase
  end

endmodule

// ===== hw/rtl/rkm_queue.sv =====
// ----------------------------------------------------------------------------
// rkm_queue
// Short command queue between the front and back ends.
// ----------------------------------------------------------------------------
module rkm_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  rkm_pkg::cmd_t push_cmd,
  output logic          full,
  output logic          head_valid,
  output rkm_pkg::cmd_t head_cmd,
  input  logic          pop
);
  import rkm_pkg::*;

  cmd_t              entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   fill_r, fill_nxt;

  assign full       = (fill_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign head_valid = (fill_r != '0);
  assign head_cmd   = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    fill_nxt = fill_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== hw/rtl/rkm_back.sv =====
// ----------------------------------------------------------------------------
// rkm_back
// Executes commands: keypoint loads, nearest-keypoint scans over the key
// memory, match updates and match reads. Holds the result register.
// ----------------------------------------------------------------------------
module rkm_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  rkm_pkg::cmd_t      q_cmd,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output rkm_pkg::out_item_t out_item
);
  import rkm_pkg::*;

  function automatic logic [KEY_W-1:0] abs_diff(input logic [KEY_W-1:0] a,
                                                input logic [KEY_W-1:0] b);
    abs_diff = (a >= b) ? (a - b) : (b - a);
  endfunction

  back_state_t state_r, state_nxt;
  cmd_t        cur_r;

  // memories
  logic [2*KEY_W-1:0]   key_mem  [MAX_POINTS];
  logic [2*COORD_W-1:0] dest_mem [MAX_POINTS];
  logic [2*KEY_W-1:0]   key_rd_r;
  logic [2*COORD_W-1:0] dest_rd_r;
  logic [MAX_POINTS-1:0] flags_r;

  logic key_we, key_ren, dest_we, dest_ren, load_out, out_free;
  logic issue_last;
  logic [CNT_W-1:0] issue_cnt_r;
  out_item_t res;

  // scan pipeline
  logic v1_r, v2_r, v3_r, l1_r, l2_r, l3_r;
  logic [PIDX_W-1:0] i1_r, i2_r, i3_r;
  logic [KEY_W-1:0]  adx_r, ady_r;
  logic [SQ_W-1:0]   sqx_r, sqy_r;
  logic [DIST_W-1:0] dist_sum;
  logic [DIST_W-1:0] best_r;
  logic [PIDX_W-1:0] best_i_r;
  logic [KEY_W-1:0]  fx, fy;

  logic              out_valid_r;
  out_item_t         out_item_r;

  assign out_free   = !out_valid_r || !out_stall;
  assign issue_last = (issue_cnt_r == cur_r.count - 1'b1);
  assign fx         = {cur_r.src_x, FRAC_W'(0)};
  assign fy         = {cur_r.src_y, FRAC_W'(0)};
  assign dist_sum   = DIST_W'(sqx_r) + DIST_W'(sqy_r);
  assign out_valid  = out_valid_r;
  assign out_item   = out_item_r;

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    key_we    = 1'b0;
    key_ren   = 1'b0;
    dest_we   = 1'b0;
    dest_ren  = 1'b0;
    load_out  = 1'b0;
    res       = '0;
    unique case (state_r)
      B_IDLE: begin
        if (q_valid && out_free) begin
          q_pop = 1'b1;
          unique case (q_cmd.kind)
            CMD_LOAD: begin
              key_we   = 1'b1;
              load_out = 1'b1;
              res.matched_index = q_cmd.idx;
            end
            CMD_SCAN: state_nxt = B_SCAN;
            CMD_READ: begin
              dest_ren  = 1'b1;
              state_nxt = B_READ;
            end
            default: load_out = 1'b1;
          endcase
        end
      end
      B_SCAN: begin
        key_ren = 1'b1;
        if (issue_last) begin
          state_nxt = B_DRAIN;
        end
      end
      B_DRAIN: begin
        if (v3_r && l3_r) begin
          state_nxt = B_COMMIT;
        end
      end
      B_COMMIT: begin
        load_out = 1'b1;
        res.matched_index = best_i_r;
        if (best_r < ONE_PIXEL_SQ) begin
          dest_we      = 1'b1;
          res.accepted = 1'b1;
          res.match_x  = cur_r.pix_x;
          res.match_y  = cur_r.pix_y;
        end
        state_nxt = B_IDLE;
      end
      B_READ: begin
        load_out = 1'b1;
        res.matched_index = cur_r.idx;
        if (flags_r[cur_r.idx]) begin
          res.has_match = 1'b1;
          res.match_x   = dest_rd_r[2*COORD_W-1:COORD_W];
          res.match_y   = dest_rd_r[COORD_W-1:0];
        end
        state_nxt = B_IDLE;
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_cmd;
    end
    if (q_pop) begin
      issue_cnt_r <= '0;
    end else if (key_ren) begin
      issue_cnt_r <= issue_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[q_cmd.idx] <= {q_cmd.key_x, q_cmd.key_y};
    end
    if (key_ren) begin
      key_rd_r <= key_mem[issue_cnt_r[PIDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (dest_we) begin
      dest_mem[best_i_r] <= {cur_r.pix_x, cur_r.pix_y};
    end
    if (dest_ren) begin
      dest_rd_r <= dest_mem[q_cmd.idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
    end else if (dest_we) begin
      flags_r[best_i_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= key_ren;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    l1_r  <= issue_last;
    i1_r  <= issue_cnt_r[PIDX_W-1:0];
    l2_r  <= l1_r;
    i2_r  <= i1_r;
    adx_r <= abs_diff(key_rd_r[2*KEY_W-1:KEY_W], fx);
    ady_r <= abs_diff(key_rd_r[KEY_W-1:0], fy);
    l3_r  <= l2_r;
    i3_r  <= i2_r;
    sqx_r <= adx_r * adx_r;
    sqy_r <= ady_r * ady_r;
    // lowest index wins ties: strict compare
    if (v3_r && ((i3_r == '0) || (dist_sum < best_r))) begin
      best_r   <= dist_sum;
      best_i_r <= i3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_item_r <= res;
    end
  end

endmodule
